// ===== sv/sfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants for the serial frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0] HDR_FIRST     = 8'hAA;
  localparam logic [7:0] HDR_SECOND    = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT    = 8'hF1;
  localparam logic [7:0] MAX_LEN_RESET = 8'd49;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_FUNC    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_GOOD   = 2'd1,
    ST_BAD    = 2'd2,
    ST_RESYNC = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] frame_len;
    logic [7:0] func_code;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic       payload_valid;
    status_t    status;
  } result_t;

endpackage

// ===== sv/sfr_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_parser
// frame phase tracking, running checksum and per-item result logic
// ----------------------------------------------------------------------------
module sfr_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       max_len,
  output sfr_pkg::result_t result
);

  sfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] byte_pos_r, byte_pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] held_func_r, held_func_nxt;
  logic [7:0] held_len_r, held_len_nxt;
  logic       abort;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sfr_pkg::PH_HUNT;
      bytes_left_r <= '0;
      byte_pos_r   <= '0;
      sum_r        <= '0;
      held_func_r  <= '0;
      held_len_r   <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      byte_pos_r   <= byte_pos_nxt;
      sum_r        <= sum_nxt;
      held_func_r  <= held_func_nxt;
      held_len_r   <= held_len_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    byte_pos_nxt   = byte_pos_r;
    sum_nxt        = sum_r;
    held_func_nxt  = held_func_r;
    held_len_nxt   = held_len_r;
    abort          = 1'b0;
    result         = '0;
    result.status  = sfr_pkg::ST_BUSY;

    unique case (phase_r)
      sfr_pkg::PH_HUNT: begin
        if (rx_byte == sfr_pkg::HDR_FIRST) begin
          sum_nxt   = rx_byte;
          phase_nxt = sfr_pkg::PH_HDR2;
        end
      end
      sfr_pkg::PH_HDR2: begin
        if (rx_byte == sfr_pkg::HDR_SECOND) begin
          sum_nxt   = sum_r + rx_byte;
          phase_nxt = sfr_pkg::PH_FUNC;
        end else begin
          abort = 1'b1;
        end
      end
      sfr_pkg::PH_FUNC: begin
        if (rx_byte != '0 && rx_byte < sfr_pkg::FUNC_LIMIT) begin
          sum_nxt       = sum_r + rx_byte;
          held_func_nxt = rx_byte;
          phase_nxt     = sfr_pkg::PH_LEN;
        end else begin
          abort = 1'b1;
        end
      end
      sfr_pkg::PH_LEN: begin
        if (rx_byte <= max_len) begin
          sum_nxt        = sum_r + rx_byte;
          held_len_nxt   = rx_byte;
          bytes_left_nxt = rx_byte;
          byte_pos_nxt   = '0;
          phase_nxt      = (rx_byte == '0) ? sfr_pkg::PH_CHECK : sfr_pkg::PH_PAYLOAD;
        end else begin
          abort = 1'b1;
        end
      end
      sfr_pkg::PH_PAYLOAD: begin
        if (bytes_left_r != '0) begin
          result.payload_valid = 1'b1;
          result.payload_byte  = rx_byte;
          result.payload_index = byte_pos_r;
          sum_nxt              = sum_r + rx_byte;
          byte_pos_nxt         = byte_pos_r + 8'd1;
          bytes_left_nxt       = bytes_left_r - 8'd1;
          if (bytes_left_r == 8'd1) begin
            phase_nxt = sfr_pkg::PH_CHECK;
          end
        end else begin
          abort = 1'b1;
        end
      end
      sfr_pkg::PH_CHECK: begin
        result.status    = (rx_byte == sum_r) ? sfr_pkg::ST_GOOD : sfr_pkg::ST_BAD;
        result.func_code = held_func_r;
        result.frame_len = held_len_r;
        phase_nxt        = sfr_pkg::PH_HUNT;
      end
      default: begin
        abort = 1'b1;
      end
    endcase

    if (abort) begin
      phase_nxt     = sfr_pkg::PH_HUNT;
      result.status = sfr_pkg::ST_RESYNC;
    end
  end

endmodule

// ===== sv/sfr_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_out_stage
// result register with stream handshake toward the consumer
// ----------------------------------------------------------------------------
module sfr_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sfr_pkg::result_t result,
  input  logic             out_ready,
  output logic             can_load,
  output logic             out_valid,
  output sfr_pkg::result_t out_result
);

  logic             valid_r, valid_nxt;
  sfr_pkg::result_t data_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = data_r;

endmodule

// ===== sv/serial_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver
// path: an accepted item passes the input register, then the result register, to out_tvalid
// throughput: one item per cycle while out_tready keeps the result register free
// reset: synchronous active-low rst_n returns to hunting, clears the checksum,
// empties both registers and loads max_payload_len with 49
// ----------------------------------------------------------------------------
module serial_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // payload_byte, payload_index, func_code, frame_len
  output logic [2:0]  out_tuser,  // status, payload_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // max_payload_len
);

  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic [7:0]       max_len_r;
  logic             can_load;
  logic             step;
  sfr_pkg::result_t result;
  sfr_pkg::result_t out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= sfr_pkg::MAX_LEN_RESET;
    end else if (cfg_valid) begin
      max_len_r <= cfg_data;
    end
  end

  // input register
  assign step      = in_valid_r && can_load;
  assign in_tready = !in_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  sfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .max_len (max_len_r),
    .result  (result)
  );

  sfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .result     (result),
    .out_ready  (out_tready),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_result (out_result)
  );

  assign out_tdata = {out_result.frame_len, out_result.func_code,
                      out_result.payload_index, out_result.payload_byte};
  assign out_tuser = {out_result.payload_valid, out_result.status};

endmodule
